/* src/tlssni_pkg.sv */
// ---------------------------------------------------------------------------
// tlssni_pkg
// Types and constants shared by the server-name extractor front end, queue
// and parser.
// ---------------------------------------------------------------------------
package tlssni_pkg;

    // record and handshake codes
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;

    // fixed field lengths in bytes
    localparam int REC_HDR_BYTES  = 5;
    localparam int HS_LEN_BYTES   = 3;
    localparam int VERSION_BYTES  = 2;
    localparam int RANDOM_BYTES   = 32;
    localparam int LEN16_BYTES    = 2;
    localparam int SN_HDR_BYTES   = 5;
    localparam int SN_LEN_OFFSET  = 3;
    localparam int EXT_HDR_BYTES  = 4;

    // byte position counter holds up to the random length
    localparam int POS_W = $clog2(RANDOM_BYTES + 1);

    // default depth of the queue between front end and parser
    localparam int QUEUE_DEPTH_DEF = 4;

    // result kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_NONE = 2'd1;
    localparam logic [1:0] KIND_CUT  = 2'd2;

    // parser phases
    typedef enum logic [4:0] {
        PH_REC,
        PH_HS_TYPE,
        PH_HS_LEN,
        PH_VER,
        PH_RAND,
        PH_SID_LEN,
        PH_SID,
        PH_CS_LEN,
        PH_CS,
        PH_COMP_LEN,
        PH_COMP,
        PH_EXT_LEN,
        PH_EXT_TYPE,
        PH_EXT_SIZE,
        PH_EXT_BODY,
        PH_SN_HDR,
        PH_NAME
    } phase_t;

    // one input transfer
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       final_byte;
    } payload_t;

    // one result transfer
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] name_byte;
        logic       name_end;
    } result_t;

    // classified byte handed from front end to parser
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_zero;
        logic       is_handshake;
        logic       is_hello;
    } token_t;

endpackage

/* src/tls_client_hello_sni_extractor.sv */
// A byte accepted at the input passes the front register, a queue entry and
// the parser output register before its result, if any, is valid.
// Throughput: one payload byte per cycle while results are taken, set by the
// single-byte parser step. The queue absorbs output stalls; input stalls once
// the queue and the front register are both full.
// Reset: asynchronous, active low; clears parser state and empties all stages.
// ---------------------------------------------------------------------------
// tls_client_hello_sni_extractor
// Extracts the server-name bytes from the ClientHello at the head of a TCP
// payload stream, one byte per transfer.
// ---------------------------------------------------------------------------
module tls_client_hello_sni_extractor #(
    parameter int QUEUE_DEPTH = tlssni_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 payload_valid,
    output logic                 payload_ready,
    input  tlssni_pkg::payload_t payload,
    output logic                 result_valid,
    input  logic                 result_ready,
    output tlssni_pkg::result_t  result
);
    import tlssni_pkg::*;

    logic   front_valid;
    logic   front_ready;
    token_t front_tok;
    logic   back_valid;
    logic   back_ready;
    token_t back_tok;

    // input register and byte classification
    tlssni_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload       (payload),
        .tok_valid     (front_valid),
        .tok_ready     (front_ready),
        .tok           (front_tok)
    );

    // decoupling queue
    tlssni_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_tok    (back_tok)
    );

    // header walk and name output
    tlssni_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (back_valid),
        .tok_ready    (back_ready),
        .tok          (back_tok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* src/tlssni_front.sv */
// ---------------------------------------------------------------------------
// tlssni_front
// Input register stage: takes payload bytes and tags each with the byte
// classes the parser tests against.
// ---------------------------------------------------------------------------
module tlssni_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 payload_valid,
    output logic                 payload_ready,
    input  tlssni_pkg::payload_t payload,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output tlssni_pkg::token_t   tok
);
    import tlssni_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_next;
    logic   take;

    // accept when the stage is empty or draining this cycle
    assign payload_ready = !valid_reg || tok_ready;
    assign take          = payload_valid && payload_ready;

    // classify the incoming byte
    always_comb
    begin
        tok_next.data         = payload.payload_byte;
        tok_next.last         = payload.final_byte;
        tok_next.is_zero      = (payload.payload_byte == 8'h00);
        tok_next.is_handshake = (payload.payload_byte == REC_HANDSHAKE);
        tok_next.is_hello     = (payload.payload_byte == HS_CLIENT_HELLO);
    end

    // stage occupancy
    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

/* src/tlssni_queue.sv */
// ---------------------------------------------------------------------------
// tlssni_queue
// Short first-in first-out queue of classified bytes between the front end
// and the parser.
// ---------------------------------------------------------------------------
module tlssni_queue #(
    parameter int DEPTH = tlssni_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tlssni_pkg::token_t push_tok,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tlssni_pkg::token_t pop_tok
);
    import tlssni_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

/* src/tlssni_back.sv */
// ---------------------------------------------------------------------------
// tlssni_back
// ClientHello parser: walks record, handshake and extension headers one byte
// per cycle unless stalled; emits server-name bytes into an output register.
// ---------------------------------------------------------------------------
module tlssni_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_valid,
    output logic                 tok_ready,
    input  tlssni_pkg::token_t   tok,
    output logic                 result_valid,
    input  logic                 result_ready,
    output tlssni_pkg::result_t  result
);
    import tlssni_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [15:0]        field_reg;
    logic [15:0]        field_next;
    logic [23:0]        hello_len_reg;
    logic [23:0]        hello_len_next;
    logic [23:0]        hello_cnt_reg;
    logic [23:0]        hello_cnt_next;
    logic [15:0]        ext_rem_reg;
    logic [15:0]        ext_rem_next;
    logic [15:0]        ext_type_reg;
    logic [15:0]        ext_type_next;
    logic [15:0]        name_rem_reg;
    logic [15:0]        name_rem_next;
    logic               finished_reg;
    logic               finished_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    result_t            res_reg;
    result_t            res_next;

    logic               fire;
    logic               emit;
    logic [POS_W-1:0]   pos_inc;
    logic [15:0]        field_dec;
    logic [15:0]        field_shift;
    logic [23:0]        hello_cnt_inc;
    logic               hello_done;
    logic [15:0]        ext_shift;
    logic [16:0]        ext_total;
    logic               ext_overrun;
    logic [15:0]        name_dec;
    logic [15:0]        name_hdr_val;

    // a byte is taken when the output register can hold its result
    assign tok_ready = !res_valid_reg || result_ready;
    assign fire      = tok_valid && tok_ready;

    // shared arithmetic
    assign pos_inc       = pos_reg + 1'b1;
    assign field_dec     = field_reg - 1'b1;
    assign field_shift   = {field_reg[7:0], tok.data};
    assign hello_cnt_inc = hello_cnt_reg + 1'b1;
    assign hello_done    = (hello_cnt_inc == hello_len_reg);
    assign ext_shift     = {ext_rem_reg[7:0], tok.data};
    assign ext_total     = {1'b0, field_shift} + 17'(EXT_HDR_BYTES);
    assign ext_overrun   = (ext_total >= {1'b0, ext_rem_reg});
    assign name_dec      = name_rem_reg - 1'b1;
    assign name_hdr_val  = (pos_reg >= POS_W'(SN_LEN_OFFSET)) ?
                           {name_rem_reg[7:0], tok.data} : name_rem_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (tok.last)
            begin
                phase_next = PH_REC;
            end
            else if (!finished_reg)
            begin
                case (phase_reg)
                    PH_REC:
                    begin
                        if (!(pos_reg == '0 && !tok.is_handshake) &&
                            pos_inc >= POS_W'(REC_HDR_BYTES))
                        begin
                            phase_next = PH_HS_TYPE;
                        end
                    end
                    PH_HS_TYPE:
                    begin
                        if (tok.is_hello)
                        begin
                            phase_next = PH_HS_LEN;
                        end
                    end
                    PH_HS_LEN:
                    begin
                        if (pos_inc >= POS_W'(HS_LEN_BYTES))
                        begin
                            phase_next = PH_VER;
                        end
                    end
                    PH_VER:
                    begin
                        if (pos_inc >= POS_W'(VERSION_BYTES))
                        begin
                            phase_next = PH_RAND;
                        end
                    end
                    PH_RAND:
                    begin
                        if (pos_inc >= POS_W'(RANDOM_BYTES))
                        begin
                            phase_next = PH_SID_LEN;
                        end
                    end
                    PH_SID_LEN:
                    begin
                        phase_next = tok.is_zero ? PH_CS_LEN : PH_SID;
                    end
                    PH_SID:
                    begin
                        if (field_dec == '0)
                        begin
                            phase_next = PH_CS_LEN;
                        end
                    end
                    PH_CS_LEN:
                    begin
                        if (pos_inc >= POS_W'(LEN16_BYTES))
                        begin
                            phase_next = (field_shift == '0) ? PH_COMP_LEN : PH_CS;
                        end
                    end
                    PH_CS:
                    begin
                        if (field_dec == '0)
                        begin
                            phase_next = PH_COMP_LEN;
                        end
                    end
                    PH_COMP_LEN:
                    begin
                        if (!tok.is_zero)
                        begin
                            phase_next = PH_COMP;
                        end
                        else if (!hello_done)
                        begin
                            phase_next = PH_EXT_LEN;
                        end
                    end
                    PH_COMP:
                    begin
                        if (field_dec == '0 && !hello_done)
                        begin
                            phase_next = PH_EXT_LEN;
                        end
                    end
                    PH_EXT_LEN:
                    begin
                        if (pos_inc >= POS_W'(LEN16_BYTES) && ext_shift != '0)
                        begin
                            phase_next = PH_EXT_TYPE;
                        end
                    end
                    PH_EXT_TYPE:
                    begin
                        if (pos_inc >= POS_W'(LEN16_BYTES))
                        begin
                            phase_next = PH_EXT_SIZE;
                        end
                    end
                    PH_EXT_SIZE:
                    begin
                        if (pos_inc >= POS_W'(LEN16_BYTES))
                        begin
                            if (ext_type_reg == EXT_SERVER_NAME)
                            begin
                                phase_next = PH_SN_HDR;
                            end
                            else if (!ext_overrun)
                            begin
                                phase_next = (field_shift == '0) ? PH_EXT_TYPE : PH_EXT_BODY;
                            end
                        end
                    end
                    PH_EXT_BODY:
                    begin
                        if (field_dec == '0)
                        begin
                            phase_next = PH_EXT_TYPE;
                        end
                    end
                    PH_SN_HDR:
                    begin
                        if (pos_inc >= POS_W'(SN_HDR_BYTES) && name_hdr_val != '0)
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // counters, length fields and the emitted result
    always_comb
    begin
        pos_next       = pos_reg;
        field_next     = field_reg;
        hello_len_next = hello_len_reg;
        hello_cnt_next = hello_cnt_reg;
        ext_rem_next   = ext_rem_reg;
        ext_type_next  = ext_type_reg;
        name_rem_next  = name_rem_reg;
        finished_next  = finished_reg;
        emit           = 1'b0;
        res_next       = '{kind: KIND_NONE, name_byte: 8'h00, name_end: 1'b0};

        if (fire)
        begin
            if (!finished_reg)
            begin
                case (phase_reg)
                    PH_REC:
                    begin
                        if (pos_reg == '0 && !tok.is_handshake)
                        begin
                            finished_next = 1'b1;
                            emit          = 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= POS_W'(REC_HDR_BYTES))
                            begin
                                pos_next   = '0;
                                field_next = '0;
                            end
                        end
                    end
                    PH_HS_TYPE:
                    begin
                        if (!tok.is_hello)
                        begin
                            finished_next = 1'b1;
                            emit          = 1'b1;
                        end
                        else
                        begin
                            hello_len_next = '0;
                            pos_next       = '0;
                            field_next     = '0;
                        end
                    end
                    PH_HS_LEN:
                    begin
                        hello_len_next = {hello_len_reg[15:0], tok.data};
                        pos_next       = pos_inc;
                        if (pos_inc >= POS_W'(HS_LEN_BYTES))
                        begin
                            hello_cnt_next = '0;
                            pos_next       = '0;
                            field_next     = '0;
                        end
                    end
                    PH_VER:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        pos_next       = pos_inc;
                        if (pos_inc >= POS_W'(VERSION_BYTES))
                        begin
                            pos_next   = '0;
                            field_next = '0;
                        end
                    end
                    PH_RAND:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        pos_next       = pos_inc;
                        if (pos_inc >= POS_W'(RANDOM_BYTES))
                        begin
                            pos_next   = '0;
                            field_next = '0;
                        end
                    end
                    PH_SID_LEN:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        if (tok.is_zero)
                        begin
                            pos_next   = '0;
                            field_next = '0;
                        end
                        else
                        begin
                            field_next = {8'h00, tok.data};
                        end
                    end
                    PH_SID, PH_CS:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        field_next     = field_dec;
                        if (field_dec == '0)
                        begin
                            pos_next = '0;
                        end
                    end
                    PH_CS_LEN:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        field_next     = field_shift;
                        pos_next       = pos_inc;
                        if (pos_inc >= POS_W'(LEN16_BYTES) && field_shift == '0)
                        begin
                            pos_next = '0;
                        end
                    end
                    PH_COMP_LEN:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        if (!tok.is_zero)
                        begin
                            field_next = {8'h00, tok.data};
                        end
                        else if (hello_done)
                        begin
                            finished_next = 1'b1;
                            emit          = 1'b1;
                        end
                        else
                        begin
                            ext_rem_next = '0;
                            pos_next     = '0;
                            field_next   = '0;
                        end
                    end
                    PH_COMP:
                    begin
                        hello_cnt_next = hello_cnt_inc;
                        field_next     = field_dec;
                        if (field_dec == '0)
                        begin
                            if (hello_done)
                            begin
                                finished_next = 1'b1;
                                emit          = 1'b1;
                            end
                            else
                            begin
                                ext_rem_next = '0;
                                pos_next     = '0;
                            end
                        end
                    end
                    PH_EXT_LEN:
                    begin
                        ext_rem_next = ext_shift;
                        pos_next     = pos_inc;
                        if (pos_inc >= POS_W'(LEN16_BYTES))
                        begin
                            if (ext_shift == '0)
                            begin
                                finished_next = 1'b1;
                                emit          = 1'b1;
                            end
                            else
                            begin
                                ext_type_next = '0;
                                pos_next      = '0;
                                field_next    = '0;
                            end
                        end
                    end
                    PH_EXT_TYPE:
                    begin
                        ext_type_next = {ext_type_reg[7:0], tok.data};
                        pos_next      = pos_inc;
                        if (pos_inc >= POS_W'(LEN16_BYTES))
                        begin
                            pos_next   = '0;
                            field_next = '0;
                        end
                    end
                    PH_EXT_SIZE:
                    begin
                        field_next = field_shift;
                        pos_next   = pos_inc;
                        if (pos_inc >= POS_W'(LEN16_BYTES))
                        begin
                            if (ext_type_reg == EXT_SERVER_NAME)
                            begin
                                name_rem_next = '0;
                                pos_next      = '0;
                                field_next    = '0;
                            end
                            else if (ext_overrun)
                            begin
                                // list exhausted, remaining length saturates
                                ext_rem_next  = '0;
                                finished_next = 1'b1;
                                emit          = 1'b1;
                            end
                            else
                            begin
                                ext_rem_next = ext_rem_reg - ext_total[15:0];
                                pos_next     = '0;
                                if (field_shift == '0)
                                begin
                                    ext_type_next = '0;
                                    field_next    = '0;
                                end
                            end
                        end
                    end
                    PH_EXT_BODY:
                    begin
                        field_next = field_dec;
                        if (field_dec == '0)
                        begin
                            ext_type_next = '0;
                            pos_next      = '0;
                        end
                    end
                    PH_SN_HDR:
                    begin
                        name_rem_next = name_hdr_val;
                        pos_next      = pos_inc;
                        if (pos_inc >= POS_W'(SN_HDR_BYTES))
                        begin
                            if (name_hdr_val == '0)
                            begin
                                finished_next = 1'b1;
                                emit          = 1'b1;
                            end
                            else
                            begin
                                pos_next   = '0;
                                field_next = '0;
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        name_rem_next      = name_dec;
                        emit               = 1'b1;
                        res_next.kind      = KIND_NAME;
                        res_next.name_byte = tok.data;
                        if (name_dec == '0)
                        begin
                            finished_next     = 1'b1;
                            res_next.name_end = 1'b1;
                        end
                        else if (tok.last)
                        begin
                            finished_next     = 1'b1;
                            res_next.kind     = KIND_CUT;
                            res_next.name_end = 1'b1;
                        end
                    end
                    default:
                    begin
                        finished_next = 1'b1;
                        emit          = 1'b1;
                    end
                endcase
            end

            // end of payload: report no name if nothing was decided, then clear
            if (tok.last)
            begin
                if (!finished_reg && !emit)
                begin
                    emit = 1'b1;
                end
                pos_next       = '0;
                field_next     = '0;
                hello_len_next = '0;
                hello_cnt_next = '0;
                ext_rem_next   = '0;
                ext_type_next  = '0;
                name_rem_next  = '0;
                finished_next  = 1'b0;
            end
        end
    end

    // output register occupancy
    always_comb
    begin
        if (fire && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_REC;
            pos_reg       <= '0;
            field_reg     <= '0;
            hello_len_reg <= '0;
            hello_cnt_reg <= '0;
            ext_rem_reg   <= '0;
            ext_type_reg  <= '0;
            name_rem_reg  <= '0;
            finished_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            field_reg     <= field_next;
            hello_len_reg <= hello_len_next;
            hello_cnt_reg <= hello_cnt_next;
            ext_rem_reg   <= ext_rem_next;
            ext_type_reg  <= ext_type_next;
            name_rem_reg  <= name_rem_next;
            finished_reg  <= finished_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
